// ===== rtl/triangle_texcoord_assembler_macros.svh =====
// Assertion macros shared by the triangle texcoord assembler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TRIANGLE_TEXCOORD_ASSEMBLER_MACROS_SVH
`define TRIANGLE_TEXCOORD_ASSEMBLER_MACROS_SVH

`ifndef SYNTHESIS
`define TCA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tca assertion failed");
`define TCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tca assertion failed");
`else
`define TCA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tca_pkg.sv =====
// Types and constants of the triangle texcoord assembler.
// No dependencies; imported by every module of the block.
`default_nettype none

package tca_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int COORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRAW_MODE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_COUNT = 2'd1;

   localparam logic [1:0] MODE_LIST  = 2'd0;
   localparam logic [1:0] MODE_STRIP = 2'd1;
   localparam logic [1:0] MODE_FAN   = 2'd2;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_CLOSE  = 2'd2;

   // count / 3 == (count * THIRD_RECIP) >> THIRD_SHIFT for every 16-bit count
   localparam int THIRD_SHIFT = 17;
   localparam logic [THIRD_SHIFT-1:0] THIRD_RECIP = 17'd43691;

   localparam logic [COUNT_WIDTH-1:0] MIN_STRIP_VERTICES = 16'd3;
   localparam logic [COUNT_WIDTH-1:0] STRIP_OVERHEAD     = 16'd2;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] u;
      logic [COORD_WIDTH-1:0] v;
   } vertex_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] coord_u;
      logic [COORD_WIDTH-1:0] coord_v;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] tri_index;
      logic [COUNT_WIDTH-1:0] row_stride;
      logic [COORD_WIDTH-1:0] corner0_u;
      logic [COORD_WIDTH-1:0] corner0_v;
      logic [COORD_WIDTH-1:0] corner1_u;
      logic [COORD_WIDTH-1:0] corner1_v;
      logic [COORD_WIDTH-1:0] corner2_u;
      logic [COORD_WIDTH-1:0] corner2_v;
      logic                   batch_end;
      logic                   bad_mode;
   } rsp_payload_type;

   // one queued triangle; pad asks the back end for a trailing copy
   typedef struct packed {
      rsp_payload_type result;
      logic            pad;
   } tri_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/tca_front.sv =====
// Front end: register file, vertex history and triangle classification.
// Depends on tca_pkg; feeds tri_cmd_type commands to tca_queue.
`default_nettype none

module tca_front
   import tca_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COUNT_WIDTH-1:0]     csr_wdata,
   input  wire logic                       take,
   input  wire req_payload_type            req_payload,
   output logic                            push_valid,
   output tri_cmd_type                     push_cmd
);

   logic [1:0]             mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] stride_ff, stride_in;
   logic [COUNT_WIDTH-1:0] seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0] made_ff, made_in;
   logic [1:0]             phase_ff, phase_in;
   vertex_type             center_ff, center_in;
   vertex_type             older_ff, older_in;
   vertex_type             newer_ff, newer_in;

   logic                                  wr_mode, wr_count;
   logic [COUNT_WIDTH-1:0]                cfg_count;
   logic [1:0]                            cfg_mode;
   logic [COUNT_WIDTH+THIRD_SHIFT-1:0]    third_prod;
   logic [COUNT_WIDTH-1:0]                total_list, total_strip, total_new;

   vertex_type cur, corner_a, corner_b;
   logic       last, tri_hit, bad_hit, final_real;

   assign wr_mode  = csr_write && (csr_index == CSR_DRAW_MODE);
   assign wr_count = csr_write && (csr_index == CSR_VERTEX_COUNT);
   assign cfg_mode  = wr_mode  ? csr_wdata[1:0] : mode_ff;
   assign cfg_count = wr_count ? csr_wdata : count_ff;

   assign third_prod  = {{THIRD_SHIFT{1'b0}}, cfg_count} *
                        {{COUNT_WIDTH{1'b0}}, THIRD_RECIP};
   assign total_list  = third_prod[THIRD_SHIFT +: COUNT_WIDTH];
   assign total_strip = (cfg_count >= MIN_STRIP_VERTICES) ?
                        (cfg_count - STRIP_OVERHEAD) : '0;
   assign total_new   = (cfg_mode == MODE_LIST) ? total_list : total_strip;

   assign cur.u = req_payload.coord_u;
   assign cur.v = req_payload.coord_v;
   assign last  = (seen_ff == (count_ff - COUNT_WIDTH'(1)));
   assign final_real = (made_ff == (total_ff - COUNT_WIDTH'(1)));

   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      stride_in = stride_ff;
      seen_in   = seen_ff;
      made_in   = made_ff;
      phase_in  = phase_ff;
      center_in = center_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;
      corner_a  = '0;
      corner_b  = '0;
      tri_hit   = 1'b0;
      bad_hit   = 1'b0;

      if (wr_mode || wr_count) begin
         mode_in   = cfg_mode;
         count_in  = cfg_count;
         total_in  = total_new;
         stride_in = total_new + {{(COUNT_WIDTH-1){1'b0}}, total_new[0]};
         seen_in   = '0;
         made_in   = '0;
         phase_in  = PHASE_FIRST;
      end else if (take && (count_ff != '0)) begin
         unique case (mode_ff)
            MODE_LIST: begin
               case (phase_ff)
                  PHASE_FIRST: begin
                     older_in = cur;
                     phase_in = PHASE_SECOND;
                  end
                  PHASE_SECOND: begin
                     newer_in = cur;
                     phase_in = PHASE_CLOSE;
                  end
                  default: begin
                     corner_a = older_ff;
                     corner_b = newer_ff;
                     tri_hit  = 1'b1;
                     phase_in = PHASE_FIRST;
                  end
               endcase
            end
            MODE_STRIP: begin
               tri_hit  = (seen_ff >= COUNT_WIDTH'(2));
               corner_a = made_ff[0] ? newer_ff : older_ff;
               corner_b = made_ff[0] ? older_ff : newer_ff;
               older_in = newer_ff;
               newer_in = cur;
            end
            MODE_FAN: begin
               if (seen_ff == '0) begin
                  center_in = cur;
               end
               tri_hit  = (seen_ff >= COUNT_WIDTH'(2));
               corner_a = center_ff;
               corner_b = newer_ff;
               newer_in = cur;
            end
            default: begin
               bad_hit = last;
            end
         endcase

         if (tri_hit) begin
            made_in = made_ff + COUNT_WIDTH'(1);
         end
         if (last) begin
            seen_in  = '0;
            made_in  = '0;
            phase_in = PHASE_FIRST;
         end else begin
            seen_in = seen_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_comb begin
      push_cmd = '0;
      push_valid = tri_hit || bad_hit;
      if (bad_hit) begin
         push_cmd.result.bad_mode = 1'b1;
      end else begin
         push_cmd.result.tri_index  = made_ff;
         push_cmd.result.row_stride = stride_ff;
         push_cmd.result.corner0_u  = corner_a.u;
         push_cmd.result.corner0_v  = corner_a.v;
         push_cmd.result.corner1_u  = corner_b.u;
         push_cmd.result.corner1_v  = corner_b.v;
         push_cmd.result.corner2_u  = cur.u;
         push_cmd.result.corner2_v  = cur.v;
         push_cmd.result.batch_end  = final_real && !total_ff[0];
         push_cmd.pad               = final_real && total_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LIST;
         count_ff  <= '0;
         total_ff  <= '0;
         stride_ff <= '0;
         seen_ff   <= '0;
         made_ff   <= '0;
         phase_ff  <= PHASE_FIRST;
         center_ff <= '0;
         older_ff  <= '0;
         newer_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         stride_ff <= stride_in;
         seen_ff   <= seen_in;
         made_ff   <= made_in;
         phase_ff  <= phase_in;
         center_ff <= center_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tca_queue.sv =====
// Short command queue between the front and back ends.
// Depends on tca_pkg and the assembler assertion macros.
`default_nettype none

`include "triangle_texcoord_assembler_macros.svh"

module tca_queue
   import tca_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire tri_cmd_type push_cmd,
   output logic             full,
   input  wire logic        pop,
   output logic             pop_valid,
   output tri_cmd_type      pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tri_cmd_type        entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TCA_ASSERT_IMPLY(a_no_push_when_full, clock, reset, full, !push)
   `TCA_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, !pop_valid, !pop)

endmodule

`default_nettype wire

// ===== rtl/tca_back.sv =====
// Back end: output register and pad-triangle replay.
// Depends on tca_pkg and the assembler assertion macros.
`default_nettype none

`include "triangle_texcoord_assembler_macros.svh"

module tca_back
   import tca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire tri_cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_payload_type  rsp_payload
);

   logic            rsp_valid_ff, rsp_valid_in;
   logic            pad_pending_ff, pad_pending_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cmd_pop     = out_free && !pad_pending_ff && cmd_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      pad_pending_in = pad_pending_ff;
      rsp_in         = rsp_ff;
      if (out_free) begin
         if (pad_pending_ff) begin
            rsp_in.tri_index = rsp_ff.tri_index + COUNT_WIDTH'(1);
            rsp_in.batch_end = 1'b1;
            rsp_valid_in     = 1'b1;
            pad_pending_in   = 1'b0;
         end else if (cmd_valid) begin
            rsp_in         = cmd.result;
            rsp_valid_in   = 1'b1;
            pad_pending_in = cmd.pad;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         pad_pending_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         pad_pending_ff <= pad_pending_in;
      end
   end

   `TCA_ASSERT_IMPLY(a_pad_behind_result, clock, reset, pad_pending_ff, rsp_valid_ff)
   `TCA_ASSERT_NEXT(a_pad_ends_batch, clock, reset, pad_pending_ff && rsp_ready,
                    rsp_valid_ff && rsp_ff.batch_end)
   `TCA_ASSERT_IMPLY(a_error_fields_clear, clock, reset, rsp_valid_ff && rsp_ff.bad_mode,
                     (rsp_ff.tri_index == '0) && !rsp_ff.batch_end && !pad_pending_ff)

endmodule

`default_nettype wire

// ===== rtl/triangle_texcoord_assembler.sv =====
// Top level of the triangle texcoord assembler: front end, command queue, back end.
// Depends on tca_pkg, tca_front, tca_queue and tca_back.
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_ready  req_payload_type (one vertex)
//   rsp_*        out         rsp_valid/rsp_ready  rsp_payload_type (one triangle)
//   csr_*        in          csr_write            csr_index, csr_wdata
//
// One vertex is taken per cycle while req_ready is high; its triangle is written into
// the command queue, then into the back end's output register, before rsp_valid rises.
// The back end replays an odd batch's last triangle as a pad triangle ending the batch.
// req_ready drops only while the QUEUE_DEPTH-entry command queue is full.
// Reset clears CSRs, counters, vertices, pointers and valid bits; no clearing pass.
`default_nettype none

module triangle_texcoord_assembler
   import tca_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_payload_type            req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_payload_type                 rsp_payload,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COUNT_WIDTH-1:0]     csr_wdata
);

   logic        take;
   logic        push_valid, queue_full, pop_valid, cmd_pop;
   tri_cmd_type push_cmd, pop_cmd;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   tca_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .take        (take),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   tca_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   tca_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd         (pop_cmd),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
